// ===== src/word_frequency_table_assert.svh =====
// ----------------------------------------------------------------------------
// word_frequency_table_assert
// Assertion macros for the word frequency table.
// ----------------------------------------------------------------------------
`ifndef WORD_FREQUENCY_TABLE_ASSERT_SVH
`define WORD_FREQUENCY_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define WFT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WFT_ASSERT_IMPL(label, ante, cons, msg)
`define WFT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/wft_pkg.sv =====
// ----------------------------------------------------------------------------
// wft_pkg
// Types and constants shared by the word frequency table modules.
// ----------------------------------------------------------------------------
package wft_pkg;
    localparam int MAX_WORDS  = 1024;
    localparam int MAX_CHARS  = 69;
    localparam int IDX_W      = 10;
    localparam int USED_W     = 11;
    localparam int POS_W      = 7;
    localparam int STORE_AW   = 17;
    localparam int NUM_BANKS  = 3;
    localparam int BANK_W     = 2;
    localparam int TOK_AW     = 8;

    localparam logic [2:0] ST_COUNTED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_READ_OK  = 3'd3;
    localparam logic [2:0] ST_READ_BAD = 3'd4;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [7:0]       text_byte;
        logic             last;
        logic [IDX_W-1:0] entry_index;
        logic [POS_W-1:0] char_pos;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [IDX_W-1:0]  slot_index;
        logic [31:0]       count;
        logic [USED_W-1:0] unique_count;
        logic [7:0]        word_byte;
        logic [POS_W-1:0]  word_length;
    } t_out_item;

    // one queued job: a finished token or an entry read
    typedef struct packed {
        logic              kind;
        logic              clr;
        logic [BANK_W-1:0] bank;
        logic [POS_W-1:0]  first;
        logic [POS_W-1:0]  len;
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  pos;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [TOK_AW-1:0] addr;
        logic [7:0]        data;
    } t_tok_wr;
endpackage

// ===== src/wft_front.sv =====
// ----------------------------------------------------------------------------
// wft_front
// Tokenizer: folds case, tracks stripping bounds, queues finished tokens and entry reads.
// ----------------------------------------------------------------------------
module wft_front import wft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_job     o_job,
    output t_tok_wr  o_tok_wr
);
    logic [POS_W-1:0]  r_raw, n_raw, r_first, n_first, r_lasta, n_lasta;
    logic              r_seen, n_seen, r_ended, n_ended, r_zero, n_zero;
    logic              r_pclr, n_pclr;
    logic [BANK_W-1:0] r_bank, n_bank;

    logic [7:0] c;
    logic       alnum, delim, fin, clr;

    always_comb begin
        c = i_item.text_byte;
        if (c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
        alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A);
        delim = c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
        n_raw = r_raw; n_first = r_first; n_lasta = r_lasta; n_seen = r_seen;
        n_ended = r_ended; n_zero = r_zero; n_pclr = r_pclr; n_bank = r_bank;
        fin = 1'b0;
        clr = r_pclr;
        o_push = 1'b0;
        o_job = '0;
        o_tok_wr = '0;
        if (i_accept && i_item.kind == KIND_READ) begin
            o_push = 1'b1;
            o_job.kind = KIND_READ;
            o_job.clr = r_pclr;
            o_job.idx = i_item.entry_index;
            o_job.pos = i_item.char_pos;
            n_pclr = 1'b0;
        end else if (i_accept) begin
            if (r_ended) begin
                n_raw = '0; n_first = '0; n_lasta = '0; n_seen = 1'b0;
                n_zero = 1'b0; n_ended = 1'b0;
                clr = 1'b1;
            end
            if (!n_zero) begin
                if (i_item.text_byte == 8'd0) begin
                    n_zero = 1'b1;
                    fin = 1'b1;
                end else if (delim) begin
                    fin = 1'b1;
                end else begin
                    if (n_raw < POS_W'(MAX_CHARS)) begin
                        o_tok_wr.en = 1'b1;
                        o_tok_wr.addr = TOK_AW'(r_bank * MAX_CHARS) + TOK_AW'(n_raw);
                        o_tok_wr.data = c;
                        if (alnum) begin
                            if (!n_seen) n_first = n_raw;
                            n_lasta = n_raw;
                            n_seen = 1'b1;
                        end
                        n_raw = n_raw + 1'b1;
                    end
                    fin = i_item.last;
                end
            end
            n_pclr = clr;
            if (fin) begin
                if (n_seen) begin
                    o_push = 1'b1;
                    o_job.kind = KIND_TEXT;
                    o_job.clr = clr;
                    o_job.bank = r_bank;
                    o_job.first = n_first;
                    o_job.len = n_lasta - n_first + 1'b1;
                    n_pclr = 1'b0;
                    n_bank = (r_bank == BANK_W'(NUM_BANKS - 1)) ? '0 : r_bank + 1'b1;
                end
                n_raw = '0; n_first = '0; n_lasta = '0; n_seen = 1'b0;
            end
            if (i_item.last) begin
                n_raw = '0; n_first = '0; n_lasta = '0; n_seen = 1'b0;
                n_ended = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= '0; r_first <= '0; r_lasta <= '0; r_seen <= 1'b0;
            r_ended <= 1'b1; r_zero <= 1'b0; r_pclr <= 1'b0; r_bank <= '0;
        end else begin
            r_raw <= n_raw; r_first <= n_first; r_lasta <= n_lasta; r_seen <= n_seen;
            r_ended <= n_ended; r_zero <= n_zero; r_pclr <= n_pclr; r_bank <= n_bank;
        end
    end
endmodule

// ===== src/wft_queue.sv =====
// ----------------------------------------------------------------------------
// wft_queue
// Two-entry job queue between tokenizer and table engine.
// ----------------------------------------------------------------------------
module wft_queue import wft_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== src/wft_back.sv =====
// ----------------------------------------------------------------------------
// wft_back
// Table engine: linear search, count update, insert and entry reads.
// ----------------------------------------------------------------------------
module wft_back import wft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tok_wr   i_tok_wr,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_item o_res
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_ENT  = 3'd2;
    localparam logic [2:0] S_LEN  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_HIT  = 3'd5;
    localparam logic [2:0] S_MISS = 3'd6;
    localparam logic [2:0] S_CPY  = 3'd7;

    logic [7:0]       m_store [MAX_WORDS*MAX_CHARS];
    logic [POS_W-1:0] m_len   [MAX_WORDS];
    logic [31:0]      m_freq  [MAX_WORDS];
    logic [7:0]       m_tok   [NUM_BANKS*MAX_CHARS];

    logic [7:0]       q_store, q_tok;
    logic [POS_W-1:0] q_len;
    logic [31:0]      q_freq;

    logic [2:0]          r_state, n_state;
    t_job                r_job, n_job;
    logic [IDX_W-1:0]    r_i, n_i;
    logic [USED_W-1:0]   r_used, n_used;
    logic [STORE_AW-1:0] r_base, n_base;
    logic [TOK_AW-1:0]   r_tbase, n_tbase;
    logic [POS_W-1:0]    r_j, n_j;
    logic [31:0]         r_freq, n_freq;
    logic                n_strobe;
    t_out_item           n_res;

    logic [STORE_AW-1:0] store_ra, store_wa;
    logic                store_we, len_we, freq_we;
    logic [7:0]          store_wd;
    logic [IDX_W-1:0]    lf_ra, lf_wa;
    logic [POS_W-1:0]    len_wd;
    logic [31:0]         freq_wd;
    logic [TOK_AW-1:0]   tok_ra;
    logic [USED_W-1:0]   used_eff;
    logic                last_ent;

    always_comb begin
        n_state = r_state; n_job = r_job; n_i = r_i; n_used = r_used; n_base = r_base;
        n_tbase = r_tbase; n_j = r_j; n_freq = r_freq;
        n_strobe = 1'b0; n_res = '0; o_pop = 1'b0;
        store_ra = '0; store_wa = '0; store_we = 1'b0; store_wd = q_tok;
        lf_ra = r_i; lf_wa = r_i; len_we = 1'b0; freq_we = 1'b0;
        len_wd = r_job.len; freq_wd = 32'd1;
        tok_ra = r_tbase;
        used_eff = i_job.clr ? '0 : r_used;
        last_ent = ({1'b0, r_i} + 1'b1) == r_used;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_job = i_job;
                    n_used = used_eff;
                    if (i_job.kind == KIND_READ) begin
                        lf_ra = i_job.idx;
                        if (i_job.pos < POS_W'(MAX_CHARS))
                            store_ra = STORE_AW'(i_job.idx) * STORE_AW'(MAX_CHARS)
                                       + STORE_AW'(i_job.pos);
                        n_state = S_RD;
                    end else begin
                        n_i = '0;
                        n_base = '0;
                        n_tbase = TOK_AW'(i_job.bank * MAX_CHARS) + TOK_AW'(i_job.first);
                        n_state = (used_eff == '0) ? S_MISS : S_ENT;
                    end
                end
            end
            S_RD: begin
                n_strobe = 1'b1;
                n_res.slot_index = r_job.idx;
                n_res.unique_count = r_used;
                if ({1'b0, r_job.idx} < r_used) begin
                    n_res.status = ST_READ_OK;
                    n_res.count = q_freq;
                    n_res.word_length = q_len;
                    n_res.word_byte = (r_job.pos < q_len) ? q_store : 8'd0;
                end else begin
                    n_res.status = ST_READ_BAD;
                end
                o_pop = 1'b1;
                n_state = S_IDLE;
            end
            S_ENT: begin
                lf_ra = r_i;
                n_state = S_LEN;
            end
            S_LEN: begin
                n_freq = q_freq;
                if (q_len == r_job.len) begin
                    store_ra = r_base;
                    tok_ra = r_tbase;
                    n_j = '0;
                    n_state = S_CMP;
                end else begin
                    // advance to the next entry
                    n_i = r_i + 1'b1;
                    n_base = r_base + STORE_AW'(MAX_CHARS);
                    n_state = last_ent ? S_MISS : S_ENT;
                end
            end
            S_CMP: begin
                if (q_store != q_tok) begin
                    n_i = r_i + 1'b1;
                    n_base = r_base + STORE_AW'(MAX_CHARS);
                    n_state = last_ent ? S_MISS : S_ENT;
                end else if (r_j + 1'b1 == r_job.len) begin
                    n_state = S_HIT;
                end else begin
                    n_j = r_j + 1'b1;
                    store_ra = r_base + STORE_AW'(n_j);
                    tok_ra = r_tbase + TOK_AW'(n_j);
                end
            end
            S_HIT: begin
                freq_wd = (r_freq == 32'hFFFF_FFFF) ? r_freq : r_freq + 32'd1;
                freq_we = 1'b1;
                n_strobe = 1'b1;
                n_res.status = ST_COUNTED;
                n_res.slot_index = r_i;
                n_res.count = freq_wd;
                n_res.unique_count = r_used;
                n_res.word_length = r_job.len;
                o_pop = 1'b1;
                n_state = S_IDLE;
            end
            S_MISS: begin
                if (r_used >= USED_W'(MAX_WORDS)) begin
                    n_strobe = 1'b1;
                    n_res.status = ST_DROPPED;
                    n_res.unique_count = r_used;
                    n_res.word_length = r_job.len;
                    o_pop = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    tok_ra = r_tbase;
                    n_j = '0;
                    n_state = S_CPY;
                end
            end
            S_CPY: begin
                store_we = 1'b1;
                store_wa = r_base + STORE_AW'(r_j);
                if (r_j + 1'b1 < r_job.len) begin
                    n_j = r_j + 1'b1;
                    tok_ra = r_tbase + TOK_AW'(n_j);
                end else begin
                    lf_wa = r_used[IDX_W-1:0];
                    len_we = 1'b1;
                    freq_we = 1'b1;
                    n_used = r_used + 1'b1;
                    n_strobe = 1'b1;
                    n_res.status = ST_INSERTED;
                    n_res.slot_index = r_used[IDX_W-1:0];
                    n_res.count = 32'd1;
                    n_res.unique_count = n_used;
                    n_res.word_length = r_job.len;
                    o_pop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) m_store[store_wa] <= store_wd;
        q_store <= m_store[store_ra];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) m_len[lf_wa] <= len_wd;
        if (freq_we) m_freq[lf_wa] <= freq_wd;
        q_len <= m_len[lf_ra];
        q_freq <= m_freq[lf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_wr.en) m_tok[i_tok_wr.addr] <= i_tok_wr.data;
        q_tok <= m_tok[tok_ra];
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job; r_i <= n_i; r_base <= n_base; r_tbase <= n_tbase;
        r_j <= n_j; r_freq <= n_freq; o_res <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; o_strobe <= 1'b0;
        end else begin
            r_state <= n_state; r_used <= n_used; o_strobe <= n_strobe;
        end
    end
endmodule

// ===== src/word_frequency_table.sv =====
// ----------------------------------------------------------------------------
// word_frequency_table
// Streaming word counter with an in-order table of distinct words.
// ----------------------------------------------------------------------------
// A text byte that does not end a token is taken while busy is low. A
// finished token or an entry read becomes a job in a two-entry queue; busy
// is high while that queue is full. The table engine takes a job when idle,
// then searches the entries one after another over memories with one read
// and one write port: it checks each entry's length, compares bytes when
// the lengths agree, then counts a hit, reports a drop or copies the token
// in for an insert; a read fetches the entry and reports it. Results come
// out as a one-cycle strobe and cannot be held off. There is no clearing pass.
module word_frequency_table import wft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_res
);
`include "word_frequency_table_assert.svh"

    logic    accept, push, pop, q_valid;
    t_job    job, q_job;
    t_tok_wr tok_wr;

    assign accept = start && !busy;

    wft_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_item(i_item),
        .o_push(push), .o_job(job), .o_tok_wr(tok_wr)
    );

    wft_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job), .i_pop(pop),
        .o_full(busy), .o_valid(q_valid), .o_job(q_job)
    );

    wft_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok_wr(tok_wr), .i_job_valid(q_valid),
        .i_job(q_job), .o_pop(pop), .o_strobe(o_strobe), .o_res(o_res)
    );

    `WFT_ASSERT_IMPL(a_status_range, o_strobe, o_res.status <= ST_READ_BAD, "bad status")
    `WFT_ASSERT_IMPL(a_insert_one, o_strobe && o_res.status == ST_INSERTED,
        o_res.count == 32'd1 && o_res.unique_count != '0, "insert count wrong")
    `WFT_ASSERT_IMPL(a_unique_cap, o_strobe, o_res.unique_count <= USED_W'(MAX_WORDS),
        "table overfilled")
    `WFT_ASSERT_NEXT(a_pop_strobe, pop, o_strobe, "job retired without result")
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the word frequency table: drives text and read
// words with random gaps, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import wft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_CYCLES = 6000;
    localparam int RANDOM_WORDS = 950;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    class word_tally;
        logic [7:0]  word_store [MAX_WORDS][MAX_CHARS];
        logic [6:0]  word_len [MAX_WORDS];
        logic [31:0] freq [MAX_WORDS];
        int          used;
        logic [7:0]  tok [MAX_CHARS];
        int          raw_len;
        int          first_pos;
        int          last_pos;
        bit          alnum_seen;
        bit          text_ended;
        bit          zero_seen;
        t_out_item   pending_results [$];
        int          mismatches;

        function new();
            used = 0;
            text_ended = 1;
            zero_seen = 0;
            mismatches = 0;
            clear_token();
        endfunction

        function void clear_token();
            raw_len = 0;
            first_pos = 0;
            last_pos = 0;
            alnum_seen = 0;
        endfunction

        function bit is_alnum(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function void add_byte(logic [7:0] c);
            if (raw_len >= MAX_CHARS) return;
            if (c >= "A" && c <= "Z") c = c + 8'd32;
            tok[raw_len] = c;
            if (is_alnum(c)) begin
                if (!alnum_seen) first_pos = raw_len;
                last_pos = raw_len;
                alnum_seen = 1;
            end
            raw_len++;
        endfunction

        function void finish_token();
            int len;
            int hit;
            bit same;
            t_out_item r;
            if (!alnum_seen) begin
                clear_token();
                return;
            end
            len = last_pos - first_pos + 1;
            hit = -1;
            for (int i = 0; i < used && hit < 0; i++) begin
                if (word_len[i] == len) begin
                    same = 1;
                    for (int k = 0; k < len; k++)
                        if (word_store[i][k] != tok[first_pos + k]) same = 0;
                    if (same) hit = i;
                end
            end
            r = '0;
            r.word_length = len[6:0];
            if (hit >= 0) begin
                if (freq[hit] != 32'hFFFF_FFFF) freq[hit]++;
                r.status = ST_COUNTED;
                r.slot_index = hit[IDX_W-1:0];
                r.count = freq[hit];
            end else if (used < MAX_WORDS) begin
                for (int k = 0; k < len; k++) word_store[used][k] = tok[first_pos + k];
                word_len[used] = len[6:0];
                freq[used] = 1;
                r.status = ST_INSERTED;
                r.slot_index = used[IDX_W-1:0];
                r.count = 1;
                used++;
            end else begin
                r.status = ST_DROPPED;
            end
            r.unique_count = used[USED_W-1:0];
            pending_results.push_back(r);
            clear_token();
        endfunction

        function void take_word(t_in_item w);
            t_out_item r;
            int idx;
            int pos;
            if (w.kind == KIND_READ) begin
                idx = w.entry_index;
                pos = w.char_pos;
                r = '0;
                r.slot_index = w.entry_index;
                r.unique_count = used[USED_W-1:0];
                if (idx < used) begin
                    r.status = ST_READ_OK;
                    r.count = freq[idx];
                    r.word_length = word_len[idx];
                    if (pos < word_len[idx]) r.word_byte = word_store[idx][pos];
                end else begin
                    r.status = ST_READ_BAD;
                end
                pending_results.push_back(r);
                return;
            end
            if (text_ended) begin
                used = 0;
                clear_token();
                zero_seen = 0;
                text_ended = 0;
            end
            if (!zero_seen) begin
                if (w.text_byte == CH_NUL) begin
                    zero_seen = 1;
                    finish_token();
                end else if (w.text_byte == CH_SPACE || w.text_byte == CH_TAB ||
                             w.text_byte == CH_LF || w.text_byte == CH_CR) begin
                    finish_token();
                end else begin
                    add_byte(w.text_byte);
                    if (w.last) finish_token();
                end
            end
            if (w.last) begin
                clear_token();
                text_ended = 1;
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task cmp_field(string name, longint got, longint want);
            if (got != want)
                report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        endtask

        task match_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result 0x%0h", got));
                return;
            end
            want = pending_results.pop_front();
            cmp_field("status", got.status, want.status);
            cmp_field("slot_index", got.slot_index, want.slot_index);
            cmp_field("count", got.count, want.count);
            cmp_field("unique_count", got.unique_count, want.unique_count);
            cmp_field("word_byte", got.word_byte, want.word_byte);
            cmp_field("word_length", got.word_length, want.word_length);
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  i_item = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_res;
    int        cycles = 0;
    int        sent = 0;
    word_tally tally = new();

    word_frequency_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) tally.match_result(o_res);
    end

    // hold start between back-to-back words; drop it only for a gap
    task send_word(t_in_item w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        tally.take_word(w);
        sent++;
    endtask

    task send_byte(logic [7:0] c, logic is_last);
        t_in_item w;
        w = '0;
        w.kind = KIND_TEXT;
        w.text_byte = c;
        w.last = is_last;
        w.entry_index = IDX_W'($urandom);
        w.char_pos = POS_W'($urandom);
        send_word(w);
    endtask

    task send_read(int idx, int pos);
        t_in_item w;
        w = '0;
        w.kind = KIND_READ;
        w.text_byte = 8'($urandom);
        w.last = 1'($urandom);
        w.entry_index = idx[IDX_W-1:0];
        w.char_pos = pos[POS_W-1:0];
        send_word(w);
    endtask

    function logic [7:0] alnum_char(int k);
        return (k < 10) ? 8'("0" + k) : 8'("a" + k - 10);
    endfunction

    function logic [7:0] punct_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (tally.is_alnum(c) || c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function logic [7:0] delim_char();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // one token from a small vocabulary, wrapped in random punctuation, or now and then a long random token
    task send_token();
        int vid;
        int len;
        logic [7:0] c;
        if ($urandom_range(0, 24) == 0) begin
            len = $urandom_range(60, 85);
            for (int i = 0; i < len; i++)
                send_byte($urandom_range(0, 3) == 0 ? punct_char()
                                                    : alnum_char($urandom_range(0, 35)), 1'b0);
            return;
        end
        vid = $urandom_range(0, 19);
        len = 1 + vid % 5;
        repeat ($urandom_range(0, 2)) send_byte(punct_char(), 1'b0);
        for (int i = 0; i < len; i++) begin
            c = alnum_char((vid * 7 + i * 3) % 36);
            if (c >= "a" && $urandom_range(0, 1)) c = c - 8'd32;
            send_byte(c, 1'b0);
            if (i == 0 && len > 2 && $urandom_range(0, 9) == 0) send_byte(punct_char(), 1'b0);
        end
        repeat ($urandom_range(0, 2)) send_byte(punct_char(), 1'b0);
    endtask

    task random_read();
        if ($urandom_range(0, 3) == 0) send_read($urandom_range(0, 1023), $urandom_range(0, 68));
        else send_read($urandom_range(0, tally.used + 2), $urandom_range(0, 68));
    endtask

    task random_text();
        int nwords;
        nwords = $urandom_range(3, 12);
        for (int i = 0; i < nwords; i++) begin
            if ($urandom_range(0, 5) == 0) random_read();
            if ($urandom_range(0, 29) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_token();
            repeat ($urandom_range(1, 2)) send_byte(delim_char(), 1'b0);
        end
        if ($urandom_range(0, 1)) send_token();
        send_byte($urandom_range(0, 1) ? alnum_char($urandom_range(0, 35))
                                       : 8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 2) == 0) random_read();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, stripping, folding, delimiters, zero byte, last
        send_read(0, 0);
        send_byte("A", 1'b0);
        send_byte("b", 1'b0);
        send_byte(",", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte("a", 1'b0);
        send_byte("B", 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte("-", 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte("9", 1'b0);
        send_byte(CH_CR, 1'b0);
        send_read(0, 0);
        send_read(0, 68);
        send_read(1, 0);
        send_read(2, 5);
        send_byte("q", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte("z", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte("k", 1'b1);
        send_read(1, 0);
        send_byte(8'hFF, 1'b0);
        send_byte("m", 1'b1);
        send_read(1023, 68);

        while (sent < RANDOM_WORDS) random_text();

        start <= 1'b0;
        while (tally.pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tally.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
